@@ src/hpc_pkg.sv @@
package hpc_pkg;

    localparam logic [1:0] ACT_KEY   = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [31:0] HASH_BASIS = 32'd2166136261;
    localparam logic [31:0] HASH_PRIME = 32'd16777619;
    localparam logic [31:0] STAMP_MAX  = 32'hFFFFFFFF;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] key_byte;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [7:0] slot;
        logic       hit;
        logic       evicted;
    } t_out;

    typedef enum logic [1:0] {
        CMD_LOOKUP,
        CMD_TICK,
        CMD_CLEAR
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [31:0] hash;
        logic [7:0]  len;
    } t_cmd;

    typedef enum logic [3:0] {
        B_IDLE,
        B_DIV,
        B_PRD,
        B_PCHK,
        B_CRD,
        B_CCHK,
        B_NEXT,
        B_WR,
        B_YRD,
        B_YWR,
        B_OUT
    } t_bstate;

endpackage

@@ src/hpc_ram.sv @@
module hpc_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/hpc_queue.sv @@
module hpc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hpc_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_full,
    output hpc_pkg::t_cmd o_cmd
);

    hpc_pkg::t_cmd r_buf [2];
    logic          r_wptr;
    logic          r_rptr;
    logic [1:0]    r_count;
    logic [1:0]    n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
        end
        if (i_push) begin
            r_buf[r_wptr] <= i_cmd;
        end
    end

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_cmd   = r_buf[r_rptr];

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue read while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");
`endif

endmodule

@@ src/hpc_front.sv @@
module hpc_front #(
    parameter int KEY_BYTES = 159
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  hpc_pkg::t_in                 i_data,
    input  logic                         i_q_full,
    output logic                         o_q_push,
    output hpc_pkg::t_cmd                o_q_cmd,
    input  logic                         i_done,
    output logic                         o_key_we,
    output logic [$clog2(KEY_BYTES)-1:0] o_key_waddr,
    output logic [7:0]                   o_key_wdata
);

    localparam int KA = $clog2(KEY_BYTES);

    logic [31:0] r_hash;
    logic [31:0] n_hash;
    logic [7:0]  r_len;
    logic [7:0]  n_len;
    logic        r_lock;
    logic        n_lock;
    logic        accept;
    logic        room;
    logic [31:0] mix;

    assign o_ready = !r_lock && !i_q_full;
    assign accept  = i_valid && o_ready;
    assign room    = (r_len < 8'(KEY_BYTES));
    assign mix     = (r_hash ^ 32'(i_data.key_byte)) * hpc_pkg::HASH_PRIME;

    always_comb begin
        n_hash        = r_hash;
        n_len         = r_len;
        n_lock        = r_lock && !i_done;
        o_q_push      = 1'b0;
        o_q_cmd.kind  = hpc_pkg::CMD_TICK;
        o_q_cmd.hash  = mix;
        o_q_cmd.len   = r_len;
        o_key_we      = 1'b0;
        o_key_waddr   = r_len[KA-1:0];
        o_key_wdata   = i_data.key_byte;
        if (accept) begin
            unique case (i_data.action)
                hpc_pkg::ACT_KEY: begin
                    if (room) begin
                        o_key_we = 1'b1;
                        n_hash   = mix;
                        n_len    = r_len + 8'd1;
                    end
                    if (i_data.last) begin
                        o_q_push     = 1'b1;
                        o_q_cmd.kind = hpc_pkg::CMD_LOOKUP;
                        o_q_cmd.hash = n_hash;
                        o_q_cmd.len  = n_len;
                        n_lock       = 1'b1;
                        n_hash       = hpc_pkg::HASH_BASIS;
                        n_len        = 8'd0;
                    end
                end
                hpc_pkg::ACT_TICK: begin
                    o_q_push     = 1'b1;
                    o_q_cmd.kind = hpc_pkg::CMD_TICK;
                end
                hpc_pkg::ACT_CLEAR: begin
                    o_q_push     = 1'b1;
                    o_q_cmd.kind = hpc_pkg::CMD_CLEAR;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= hpc_pkg::HASH_BASIS;
            r_len  <= 8'd0;
            r_lock <= 1'b0;
        end else begin
            r_hash <= n_hash;
            r_len  <= n_len;
            r_lock <= n_lock;
        end
    end

`ifndef NO_ASSERTIONS
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= 8'(KEY_BYTES))
        else $error("key length beyond buffer");
    a_lock_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lock |-> !o_q_push)
        else $error("command pushed while a lookup is pending");
    a_lookup_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push && o_q_cmd.kind == hpc_pkg::CMD_LOOKUP |=> r_lock || $past(i_done))
        else $error("lookup pushed without locking the key buffer");
`endif

endmodule

@@ src/hpc_back.sv @@
module hpc_back #(
    parameter int SLOTS     = 192,
    parameter int PROBES    = 8,
    parameter int KEY_BYTES = 159
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  hpc_pkg::t_cmd                i_q_cmd,
    output logic                         o_q_pop,
    output logic                         o_done,
    output logic [$clog2(KEY_BYTES)-1:0] o_in_raddr,
    input  logic [7:0]                   i_in_rdata,
    output logic                         o_valid,
    input  logic                         i_ready,
    output hpc_pkg::t_out                o_data
);

    localparam int IW  = $clog2(SLOTS);
    localparam int PW  = $clog2(PROBES) + 1;
    localparam int KA  = $clog2(KEY_BYTES);
    localparam int KAW = $clog2(SLOTS * KEY_BYTES);
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(SLOTS));

    hpc_pkg::t_bstate r_state;
    hpc_pkg::t_bstate n_state;
    logic [SLOTS-1:0] r_valid;
    logic [SLOTS-1:0] n_valid;
    logic [31:0]      r_frame;
    logic [31:0]      n_frame;
    logic [31:0]      r_v;
    logic [31:0]      n_v;
    logic [31:0]      r_divq;
    logic [31:0]      n_divq;
    logic [4:0]       r_cnt;
    logic [4:0]       n_cnt;
    logic [IW-1:0]    r_idx;
    logic [IW-1:0]    n_idx;
    logic [IW-1:0]    r_first;
    logic [IW-1:0]    n_first;
    logic [IW-1:0]    r_victim;
    logic [IW-1:0]    n_victim;
    logic             r_vf;
    logic             n_vf;
    logic [31:0]      r_oldest;
    logic [31:0]      n_oldest;
    logic [PW-1:0]    r_p;
    logic [PW-1:0]    n_p;
    logic [7:0]       r_len;
    logic [7:0]       n_len;
    logic [7:0]       r_j;
    logic [7:0]       n_j;
    logic             r_hit;
    logic             n_hit;
    logic             r_evict;
    logic             n_evict;
    logic             r_ovalid;
    logic             n_ovalid;
    hpc_pkg::t_out    r_out;
    hpc_pkg::t_out    n_out;

    logic [63:0]      recip_prod;
    logic [31:0]      rem_raw;
    logic [31:0]      rem_fix;
    logic             stamp_lt;
    logic [KAW-1:0]   key_addr;
    logic             stamp_we;
    logic             len_we;
    logic             key_we;
    logic [31:0]      stamp_rd;
    logic [7:0]       len_rd;
    logic [7:0]       key_rd;

    assign key_addr = KAW'(KAW'(r_idx) * KAW'(KEY_BYTES) + KAW'(r_j));
    assign stamp_lt = (stamp_rd < r_oldest);

    // The estimated quotient is at most one below the true one, so a single
    // compare and subtract finishes the remainder.
    assign recip_prod = 64'(r_v) * 64'(RECIP);
    assign rem_raw    = r_v - r_divq * 32'(SLOTS);
    assign rem_fix    = (r_divq >= 32'(SLOTS)) ? r_divq - 32'(SLOTS) : r_divq;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hpc_pkg::B_IDLE: begin
                if (i_q_valid && i_q_cmd.kind == hpc_pkg::CMD_LOOKUP) begin
                    n_state = hpc_pkg::B_DIV;
                end
            end
            hpc_pkg::B_DIV: begin
                if (r_cnt == 5'd2) begin
                    n_state = hpc_pkg::B_PRD;
                end
            end
            hpc_pkg::B_PRD: n_state = hpc_pkg::B_PCHK;
            hpc_pkg::B_PCHK: begin
                if (!r_valid[r_idx]) begin
                    n_state = hpc_pkg::B_WR;
                end else if (len_rd == r_len) begin
                    n_state = hpc_pkg::B_CRD;
                end else begin
                    n_state = hpc_pkg::B_NEXT;
                end
            end
            hpc_pkg::B_CRD: n_state = hpc_pkg::B_CCHK;
            hpc_pkg::B_CCHK: begin
                if (key_rd != i_in_rdata) begin
                    n_state = hpc_pkg::B_NEXT;
                end else if (r_j == r_len - 8'd1) begin
                    n_state = hpc_pkg::B_WR;
                end else begin
                    n_state = hpc_pkg::B_CRD;
                end
            end
            hpc_pkg::B_NEXT: begin
                if (r_p == PW'(PROBES - 1)) begin
                    n_state = hpc_pkg::B_WR;
                end else begin
                    n_state = hpc_pkg::B_PRD;
                end
            end
            hpc_pkg::B_WR: n_state = r_hit ? hpc_pkg::B_OUT : hpc_pkg::B_YRD;
            hpc_pkg::B_YRD: n_state = hpc_pkg::B_YWR;
            hpc_pkg::B_YWR: begin
                if (r_j == r_len - 8'd1) begin
                    n_state = hpc_pkg::B_OUT;
                end else begin
                    n_state = hpc_pkg::B_YRD;
                end
            end
            hpc_pkg::B_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_state = hpc_pkg::B_IDLE;
                end
            end
            default: n_state = hpc_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        n_valid  = r_valid;
        n_frame  = r_frame;
        n_v      = r_v;
        n_divq   = r_divq;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_first  = r_first;
        n_victim = r_victim;
        n_vf     = r_vf;
        n_oldest = r_oldest;
        n_p      = r_p;
        n_len    = r_len;
        n_j      = r_j;
        n_hit    = r_hit;
        n_evict  = r_evict;
        n_ovalid = r_ovalid && !i_ready;
        n_out    = r_out;
        o_q_pop  = 1'b0;
        o_done   = 1'b0;
        stamp_we = 1'b0;
        len_we   = 1'b0;
        key_we   = 1'b0;
        unique case (r_state)
            hpc_pkg::B_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    unique case (i_q_cmd.kind)
                        hpc_pkg::CMD_TICK:  n_frame = r_frame + 32'd1;
                        hpc_pkg::CMD_CLEAR: n_valid = '0;
                        default: begin
                            n_v      = i_q_cmd.hash;
                            n_divq   = i_q_cmd.hash;
                            n_cnt    = 5'd0;
                            n_len    = i_q_cmd.len;
                            n_p      = '0;
                            n_oldest = hpc_pkg::STAMP_MAX;
                            n_vf     = 1'b0;
                        end
                    endcase
                end
            end
            hpc_pkg::B_DIV: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd0) begin
                    n_divq = recip_prod[63:32];
                end else if (r_cnt == 5'd1) begin
                    n_divq = rem_raw;
                end else begin
                    n_idx   = rem_fix[IW-1:0];
                    n_first = rem_fix[IW-1:0];
                end
            end
            hpc_pkg::B_PCHK: begin
                n_j = 8'd0;
                if (!r_valid[r_idx]) begin
                    n_hit   = 1'b0;
                    n_evict = 1'b0;
                end
            end
            hpc_pkg::B_CCHK: begin
                if (key_rd == i_in_rdata) begin
                    if (r_j == r_len - 8'd1) begin
                        n_hit   = 1'b1;
                        n_evict = 1'b0;
                    end else begin
                        n_j = r_j + 8'd1;
                    end
                end
            end
            hpc_pkg::B_NEXT: begin
                if (stamp_lt) begin
                    n_oldest = stamp_rd;
                    n_victim = r_idx;
                    n_vf     = 1'b1;
                end
                if (r_p == PW'(PROBES - 1)) begin
                    n_idx   = n_vf ? n_victim : r_first;
                    n_hit   = 1'b0;
                    n_evict = 1'b1;
                end else begin
                    n_p = r_p + PW'(1);
                    n_v = r_v + 32'd1;
                    if (r_v == 32'hFFFFFFFF || r_idx == IW'(SLOTS - 1)) begin
                        n_idx = '0;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            hpc_pkg::B_WR: begin
                stamp_we = 1'b1;
                if (!r_hit) begin
                    len_we         = 1'b1;
                    n_valid[r_idx] = 1'b1;
                    n_j            = 8'd0;
                end
            end
            hpc_pkg::B_YWR: begin
                key_we = 1'b1;
                n_j    = r_j + 8'd1;
            end
            hpc_pkg::B_OUT: begin
                if (!r_ovalid || i_ready) begin
                    o_done        = 1'b1;
                    n_ovalid      = 1'b1;
                    n_out.slot    = 8'(r_idx);
                    n_out.hit     = r_hit;
                    n_out.evicted = r_evict;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hpc_pkg::B_IDLE;
            r_valid  <= '0;
            r_frame  <= 32'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_frame  <= n_frame;
            r_ovalid <= n_ovalid;
        end
        r_v      <= n_v;
        r_divq   <= n_divq;
        r_cnt    <= n_cnt;
        r_idx    <= n_idx;
        r_first  <= n_first;
        r_victim <= n_victim;
        r_vf     <= n_vf;
        r_oldest <= n_oldest;
        r_p      <= n_p;
        r_len    <= n_len;
        r_j      <= n_j;
        r_hit    <= n_hit;
        r_evict  <= n_evict;
        r_out    <= n_out;
    end

    assign o_in_raddr = r_j[KA-1:0];
    assign o_valid    = r_ovalid;
    assign o_data     = r_out;

    hpc_ram #(.W(32), .D(SLOTS)) u_stamp (
        .i_clk   (i_clk),
        .i_we    (stamp_we),
        .i_waddr (r_idx),
        .i_wdata (r_frame),
        .i_raddr (r_idx),
        .o_rdata (stamp_rd)
    );

    hpc_ram #(.W(8), .D(SLOTS)) u_len (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (r_idx),
        .i_wdata (r_len),
        .i_raddr (r_idx),
        .o_rdata (len_rd)
    );

    hpc_ram #(.W(8), .D(SLOTS * KEY_BYTES)) u_keys (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_addr),
        .i_wdata (i_in_rdata),
        .i_raddr (key_addr),
        .o_rdata (key_rd)
    );

`ifndef NO_ASSERTIONS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != hpc_pkg::B_IDLE && r_state != hpc_pkg::B_DIV
            |-> r_idx < IW'(SLOTS))
        else $error("slot index out of range");
    a_cmp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == hpc_pkg::B_CCHK || r_state == hpc_pkg::B_YWR |-> r_j < r_len)
        else $error("byte index past key length");
    a_filled_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_valid[r_idx])
        else $error("result slot not marked valid");
    a_done_raises: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> o_valid)
        else $error("finished lookup not presented");
`endif

endmodule

@@ src/hashed_probe_cache_lookup.sv @@
// Lookup-or-insert cache of SLOTS keys with linear probing over PROBES slots.
// Input channel (i_valid/o_ready/i_data): one beat per key byte, frame tick or
// clear. A key byte beat with last set starts a lookup; tick and clear beats
// give no result. Output channel (o_valid/i_ready/o_data): one beat per key,
// carrying the slot, a hit flag and an eviction flag.
// Key bytes are taken one per cycle while no lookup is pending and the
// command queue has room. After the last byte the back end reduces the hash
// to a slot index (a reciprocal multiply, a multiply-subtract and one
// correction), then reads and checks each probed slot, steps past each slot
// passed over, compares the key byte by byte on a slot of equal length,
// writes the stamp, on a miss copies the key bytes into the slot, and loads
// the result register. Compare and copy run byte-serially through the key
// memory port. While a lookup runs, new beats are held off; ticks and clears
// queue ahead of it in a two-entry command queue and are handled by the idle back end.
// The result sits in an output register, so a stalled receiver holds only
// that beat; the back end waits for the register to free before finishing.
// Synchronous reset empties the queue, invalidates all slots, zeroes the
// frame stamp and restarts the hash; no clearing pass is needed.
module hashed_probe_cache_lookup #(
    parameter int SLOTS     = 192,
    parameter int PROBES    = 8,
    parameter int KEY_BYTES = 159
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  hpc_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output hpc_pkg::t_out o_data
);

    localparam int KA = $clog2(KEY_BYTES);

    logic          q_push;
    logic          q_pop;
    logic          q_valid;
    logic          q_full;
    hpc_pkg::t_cmd q_in;
    hpc_pkg::t_cmd q_out;
    logic          done;
    logic          key_we;
    logic [KA-1:0] key_waddr;
    logic [7:0]    key_wdata;
    logic [KA-1:0] key_raddr;
    logic [7:0]    key_rdata;

    hpc_front #(.KEY_BYTES(KEY_BYTES)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_in),
        .i_done      (done),
        .o_key_we    (key_we),
        .o_key_waddr (key_waddr),
        .o_key_wdata (key_wdata)
    );

    hpc_ram #(.W(8), .D(KEY_BYTES)) u_inkey (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (key_wdata),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    hpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (q_out)
    );

    hpc_back #(.SLOTS(SLOTS), .PROBES(PROBES), .KEY_BYTES(KEY_BYTES)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_out),
        .o_q_pop    (q_pop),
        .o_done     (done),
        .o_in_raddr (key_raddr),
        .i_in_rdata (key_rdata),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data)
    );

endmodule

@@ sim/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 192;
    localparam int PROBES = 8;
    localparam int KEY_BYTES = 159;
    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 1200;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    hpc_pkg::t_in i_data;
    logic o_valid;
    logic i_ready;
    hpc_pkg::t_out o_data;

    hashed_probe_cache_lookup dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    // Shadow copy of the cache.
    logic [31:0] frame_stamp;
    logic [31:0] key_hash;
    logic [7:0] pend_key [KEY_BYTES];
    int pend_len;
    logic line_valid [SLOTS];
    logic [31:0] line_stamp [SLOTS];
    int line_len [SLOTS];
    logic [7:0] line_bytes [SLOTS][KEY_BYTES];

    hpc_pkg::t_out lookup_results [$];
    int mismatches;
    int results_seen;
    int hits_seen;
    int evicts_seen;
    int sender_idle_pct;
    int receiver_stall_pct;
    int idle_cycles;
    bit timed_out;

    // Key pool for reuse, so hits and probe-window collisions are common.
    logic [7:0] pool_bytes [16][KEY_BYTES];
    int pool_len [16];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit same_key(int idx);
        if (line_len[idx] != pend_len) return 1'b0;
        for (int b = 0; b < pend_len; b++)
            if (line_bytes[idx][b] !== pend_key[b]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic hpc_pkg::t_out resolve_slot();
        hpc_pkg::t_out r;
        int victim;
        int idx;
        logic [31:0] oldest;
        bit found;
        victim = -1;
        oldest = hpc_pkg::STAMP_MAX;
        found = 1'b0;
        r = '0;
        for (int p = 0; p < PROBES && !found; p++) begin
            idx = int'((key_hash + 32'(p)) % 32'(SLOTS));
            if (line_valid[idx] && same_key(idx)) begin
                victim = idx;
                r.hit = 1'b1;
                found = 1'b1;
            end else if (!line_valid[idx]) begin
                victim = idx;
                found = 1'b1;
            end else if (line_stamp[idx] < oldest) begin
                oldest = line_stamp[idx];
                victim = idx;
            end
        end
        if (victim < 0) victim = int'(key_hash % 32'(SLOTS));
        r.slot = 8'(victim);
        if (!r.hit) begin
            r.evicted = line_valid[victim];
            for (int b = 0; b < pend_len; b++) line_bytes[victim][b] = pend_key[b];
            line_len[victim] = pend_len;
            line_valid[victim] = 1'b1;
        end
        line_stamp[victim] = frame_stamp;
        key_hash = hpc_pkg::HASH_BASIS;
        pend_len = 0;
        return r;
    endfunction

    function automatic void predict_beat(hpc_pkg::t_in d);
        case (d.action)
            hpc_pkg::ACT_TICK: frame_stamp = frame_stamp + 32'd1;
            hpc_pkg::ACT_CLEAR: for (int i = 0; i < SLOTS; i++) line_valid[i] = 1'b0;
            hpc_pkg::ACT_KEY: begin
                if (pend_len < KEY_BYTES) begin
                    pend_key[pend_len] = d.key_byte;
                    pend_len++;
                    key_hash = (key_hash ^ {24'd0, d.key_byte}) * hpc_pkg::HASH_PRIME;
                end
                if (d.last) lookup_results.push_back(resolve_slot());
            end
            default: ;
        endcase
    endfunction

    task automatic send_beat(logic [1:0] act, logic [7:0] b, logic l);
        hpc_pkg::t_in d;
        d.action = act;
        d.key_byte = b;
        d.last = l;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= d;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_beat(d);
    endtask

    task automatic send_key(int n, logic [7:0] fill, bit rand_bytes);
        for (int i = 0; i < n; i++)
            send_beat(hpc_pkg::ACT_KEY, rand_bytes ? 8'($urandom_range(1, 255)) : fill,
                i == n - 1);
    endtask

    task automatic send_pool_key(int k);
        for (int i = 0; i < pool_len[k]; i++)
            send_beat(hpc_pkg::ACT_KEY, pool_bytes[k][i], i == pool_len[k] - 1);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (lookup_results.size() != 0 && !timed_out) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                hpc_pkg::t_out want;
                if (lookup_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result beat %p", o_data);
                end else begin
                    want = lookup_results.pop_front();
                    results_seen++;
                    hits_seen += want.hit;
                    evicts_seen += want.evicted;
                    if (o_data.slot !== want.slot || o_data.hit !== want.hit ||
                        o_data.evicted !== want.evicted) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected slot %0d hit %0b evicted %0b,",
                                " got slot %0d hit %0b evicted %0b"},
                                want.slot, want.hit, want.evicted,
                                o_data.slot, o_data.hit, o_data.evicted);
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog expired with %0d results outstanding", lookup_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic test_directed();
        send_key(1, 8'hFF, 0);
        send_key(1, 8'hFF, 0);
        send_key(1, 8'h00, 0);
        send_key(3, 8'h01, 0);
        send_key(KEY_BYTES, 8'h5A, 0);
        send_key(KEY_BYTES + 3, 8'h5A, 0);
        send_beat(hpc_pkg::ACT_TICK, 8'hAA, 1'b1);
        send_beat(ACT_NONE, 8'h55, 1'b1);
        send_beat(hpc_pkg::ACT_KEY, 8'h80, 1'b0);
        send_beat(hpc_pkg::ACT_TICK, 8'h00, 1'b0);
        send_beat(hpc_pkg::ACT_CLEAR, 8'hFF, 1'b0);
        send_beat(hpc_pkg::ACT_KEY, 8'h7F, 1'b1);
        send_key(1, 8'hFF, 0);
        send_beat(hpc_pkg::ACT_CLEAR, 8'h00, 1'b1);
        send_key(2, 8'h11, 0);
    endtask

    // Send SLOTS distinct two-byte keys, with a frame tick every 40 keys, to fill the table and provoke evictions.
    task automatic test_eviction();
        for (int i = 0; i < SLOTS; i++) begin
            send_beat(hpc_pkg::ACT_KEY, 8'(i), 1'b0);
            send_beat(hpc_pkg::ACT_KEY, 8'(i >> 8), 1'b1);
            if (i % 40 == 0) send_beat(hpc_pkg::ACT_TICK, 8'h00, 1'b0);
        end
    endtask

    // Every pool key goes in twice, so the second pass finds most of them stored.
    task automatic test_key_reuse();
        for (int k = 0; k < 16; k++) send_pool_key(k);
        for (int k = 0; k < 16; k++) send_pool_key(k);
    endtask

    task automatic test_random(int n);
        int sent;
        int r;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(99);
            if (r < 55) begin
                send_pool_key($urandom_range(15));
                sent += 1;
            end else if (r < 80) begin
                send_key($urandom_range(1, 6), 8'h00, 1);
                sent += 1;
            end else if (r < 85) begin
                send_beat(hpc_pkg::ACT_KEY, 8'($urandom), 1'($urandom));
                sent++;
            end else if (r < 93) begin
                send_beat(hpc_pkg::ACT_TICK, 8'($urandom), 1'($urandom));
                sent++;
            end else if (r < 96) begin
                send_beat(hpc_pkg::ACT_CLEAR, 8'($urandom), 1'($urandom));
                sent++;
            end else begin
                send_beat(ACT_NONE, 8'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_data = '0;
        frame_stamp = '0;
        key_hash = hpc_pkg::HASH_BASIS;
        pend_len = 0;
        for (int i = 0; i < SLOTS; i++) begin
            line_valid[i] = 1'b0;
            line_stamp[i] = '0;
            line_len[i] = 0;
        end
        for (int k = 0; k < 16; k++) begin
            pool_len[k] = (k == 15) ? KEY_BYTES + 2 : $urandom_range(1, 8);
            for (int b = 0; b < KEY_BYTES; b++) pool_bytes[k][b] = 8'($urandom);
        end
        mismatches = 0;
        results_seen = 0;
        hits_seen = 0;
        evicts_seen = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_eviction();
        wait_drained();
        test_key_reuse();
        test_random(16);
        sender_idle_pct = 74;
        test_random(16);
        wait_drained();
        sender_idle_pct = 0;
        receiver_stall_pct = 74;
        test_random(16);
        sender_idle_pct = 15;
        receiver_stall_pct = 15;
        test_random(16);
        wait_drained();

        $display("run covered %0d lookup results: %0d hits and %0d evictions,",
            results_seen, hits_seen, evicts_seen);
        $display("with ticks, clears, over-long keys and idle and stall phases on both sides");
        if (mismatches == 0 && lookup_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, lookup_results.size());
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
